// ===== hdl/lfp_pkg.sv =====
// Shared types and constants for the lidar frame parser.
// Used by the front end, the record queue, the back end and the top level.
// No dependencies.
package lfp_pkg;

  // Configuration register indexes.
  localparam logic [0:0] CFG_HEADER = 1'b0;
  localparam logic [0:0] CFG_WEAK   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_RESET = 8'd89;
  localparam logic [6:0] WEAK_RESET   = 7'd20;

  // Result status codes.
  localparam logic [1:0] STATUS_BAD  = 2'd0;
  localparam logic [1:0] STATUS_WEAK = 2'd1;
  localparam logic [1:0] STATUS_GOOD = 2'd2;

  // Strength ceiling.
  localparam logic [15:0] STRENGTH_CAP = 16'd100;

  // Record queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished frame as handed from the front end to the back end.
  typedef struct packed {
    logic        sum_ok;
    logic [15:0] distance_raw;
    logic [15:0] strength_raw;
  } lfp_rec_t;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_BODY  = 3'b100
  } lfp_phase_e;

endpackage

// ===== hdl/lidar_frame_parser.sv =====
// Lidar frame parser: one received byte per transfer, one result per frame.
// Throughput: one byte per cycle; the input stalls only while the two-entry
// record queue is full. A finished frame's record enters the queue when the last
// byte of its frame is accepted, then moves into the output register once that is free.
// Reset (rst_ni, asynchronous, active low) returns the parser to header hunt,
// empties the queue and output register and restores the register defaults.
module lidar_frame_parser import lfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received byte stream. tdata: rx_byte [7:0].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Results. tdata: range_mm [19:0], strength_pct [26:20], status [28:27], zero [31:29].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] header_value_q;
  logic [6:0] weak_limit_q;
  logic       byte_accept;
  logic       push, q_full, q_empty, pop;
  lfp_rec_t   rec_in, rec_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_value_q <= HEADER_RESET;
      weak_limit_q   <= WEAK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER: header_value_q <= cfg_data_i;
        CFG_WEAK:   weak_limit_q   <= cfg_data_i[6:0];
        default:    header_value_q <= header_value_q;
      endcase
    end
  end

  assign s_axis_tready_o = !q_full;
  assign byte_accept     = s_axis_tvalid_i && s_axis_tready_o;

  lfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (byte_accept),
    .byte_i         (s_axis_tdata_i),
    .header_value_i (header_value_q),
    .rec_valid_o    (push),
    .rec_o          (rec_in)
  );

  lfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rec_o   (rec_out)
  );

  lfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (!q_empty),
    .rec_i           (rec_out),
    .rec_pop_o       (pop),
    .weak_limit_i    (weak_limit_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> s_axis_tready_o)
    else $error("input stalled with an empty record queue");

endmodule

// ===== hdl/lfp_front.sv =====
// Front end of the lidar frame parser: header hunt, body capture and checksum.
// Emits one record per completed frame. Depends on lfp_pkg.
module lfp_front import lfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] header_value_i,
  output logic       rec_valid_o,
  output lfp_rec_t   rec_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);

  lfp_phase_e     phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     dist_q, dist_d;
  logic [15:0]     str_q, str_d;
  logic            is_header;

  assign is_header = (byte_i == header_value_i);

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    dist_d      = dist_q;
    str_d       = str_q;
    rec_valid_o = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        PH_HUNT2: begin
          if (is_header) begin
            sum_d   = sum_q + byte_i;
            idx_d   = IdxW'(2);
            phase_d = PH_BODY;
          end else begin
            phase_d = PH_HUNT1;
            idx_d   = '0;
            sum_d   = '0;
          end
        end
        PH_BODY: begin
          if (idx_q < LastIdx) begin
            if (idx_q == IdxW'(2)) dist_d[7:0]  = byte_i;
            if (idx_q == IdxW'(3)) dist_d[15:8] = byte_i;
            if (idx_q == IdxW'(4)) str_d[7:0]   = byte_i;
            if (idx_q == IdxW'(5)) str_d[15:8]  = byte_i;
            sum_d = sum_q + byte_i;
            idx_d = idx_q + 1'b1;
          end else begin
            rec_valid_o = 1'b1;
            phase_d     = PH_HUNT1;
            idx_d       = '0;
            sum_d       = '0;
          end
        end
        default: begin
          if (is_header) begin
            sum_d   = byte_i;
            idx_d   = IdxW'(1);
            phase_d = PH_HUNT2;
          end else begin
            phase_d = PH_HUNT1;
            idx_d   = '0;
            sum_d   = '0;
          end
        end
      endcase
    end
  end

  // Record contents are valid only together with rec_valid_o.
  assign rec_o.sum_ok       = (byte_i == sum_q);
  assign rec_o.distance_raw = dist_q;
  assign rec_o.strength_raw = str_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  // Captured fields need no reset.
  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    str_q  <= str_d;
  end

  a_rec_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> (phase_q == PH_BODY && idx_q == LastIdx))
    else $error("record emitted outside the last body byte");

  a_hunt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT1) |-> (idx_q == '0 && sum_q == '0))
    else $error("index or sum not cleared while hunting");

endmodule

// ===== hdl/lfp_queue.sv =====
// Short record queue that decouples the parser front end from the back end.
// Depends on lfp_pkg.
module lfp_queue import lfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lfp_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output lfp_rec_t rec_o
);

  lfp_rec_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== hdl/lfp_back.sv =====
// Back end of the lidar frame parser: scales distance, clamps strength,
// grades the status and holds the result in the output register. Depends on lfp_pkg.
module lfp_back import lfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  input  lfp_rec_t    rec_i,
  output logic        rec_pop_o,
  input  logic [6:0]  weak_limit_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o
);

  logic        out_valid_q;
  logic [19:0] dist_q, dist_d;
  logic [6:0]  str_q, str_d;
  logic [1:0]  status_q, status_d;
  logic [6:0]  str_clamped;
  logic [19:0] dist_mm;

  // Distance in mm is cm times ten, done as two shifts and an add.
  assign dist_mm     = {1'b0, rec_i.distance_raw, 3'b000} + {3'b000, rec_i.distance_raw, 1'b0};
  assign str_clamped = (rec_i.strength_raw > STRENGTH_CAP) ? STRENGTH_CAP[6:0]
                                                           : rec_i.strength_raw[6:0];

  // Result fields; a failed checksum reports zeros.
  always_comb begin
    if (rec_i.sum_ok) begin
      dist_d   = dist_mm;
      str_d    = str_clamped;
      status_d = (str_clamped < weak_limit_i) ? STATUS_WEAK : STATUS_GOOD;
    end else begin
      dist_d   = '0;
      str_d    = '0;
      status_d = STATUS_BAD;
    end
  end

  // Take the next record once the output register is free or being emptied.
  assign rec_pop_o = rec_valid_i && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      dist_q   <= dist_d;
      str_q    <= str_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, status_q, str_q, dist_q};

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_BAD) |-> (dist_q == '0 && str_q == '0))
    else $error("failed frame carries non-zero fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == STATUS_BAD || status_q == STATUS_WEAK
                     || status_q == STATUS_GOOD))
    else $error("unused status code on the output");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lidar_frame_parser: byte streams of good, corrupt and broken
// frames are checked against an in-bench frame tracker, over several register settings.
// Depends on lfp_pkg and the parser RTL.
module tb_top import lfp_pkg::*; ();

  localparam int unsigned FRAME_LEN      = 9;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Byte positions within a frame.
  localparam int unsigned POS_DIST_LO = 2;
  localparam int unsigned POS_DIST_HI = 3;
  localparam int unsigned POS_STR_LO  = 4;
  localparam int unsigned POS_STR_HI  = 5;

  typedef struct packed {
    logic [19:0] range_mm;
    logic [6:0]  strength_pct;
    logic [1:0]  status;
  } range_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;  // rx_byte [7:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // range_mm [19:0], strength_pct [26:20], status [28:27]
  logic        cfg_we_i        = 1'b0;
  logic [0:0]  cfg_idx_i       = CFG_HEADER;
  logic [7:0]  cfg_data_i      = '0;

  // Bytes waiting to be sent, and the results the tracker expects.
  logic [7:0]    byte_queue[$];
  range_result_t expected_results[$];

  // Register values as last written.
  logic [7:0] hdr_cfg  = HEADER_RESET;
  logic [6:0] weak_cfg = WEAK_RESET;

  // Frame tracker state.
  lfp_phase_e  parser_phase = PH_HUNT1;
  int unsigned frame_pos    = 0;
  logic [7:0]  frame_sum    = '0;
  logic [15:0] dist_cm      = '0;
  logic [15:0] strength_raw = '0;

  bit          idle_in  = 1'b1;
  bit          idle_out = 1'b1;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_cnt = 0;

  lidar_frame_parser #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Advances the frame tracker by one accepted byte; a finished frame yields a result.
  task automatic track_frame_byte(input logic [7:0] b);
    range_result_t res;
    logic [15:0]   capped;
    res = '0;
    case (parser_phase)
      PH_HUNT2: begin
        if (b == hdr_cfg) begin
          frame_sum    = frame_sum + b;
          frame_pos    = 2;
          parser_phase = PH_BODY;
        end else begin
          parser_phase = PH_HUNT1;
          frame_pos    = 0;
          frame_sum    = '0;
        end
      end
      PH_BODY: begin
        if (frame_pos < FRAME_LEN - 1) begin
          case (frame_pos)
            POS_DIST_LO: dist_cm[7:0]       = b;
            POS_DIST_HI: dist_cm[15:8]      = b;
            POS_STR_LO:  strength_raw[7:0]  = b;
            POS_STR_HI:  strength_raw[15:8] = b;
            default: ;
          endcase
          frame_sum = frame_sum + b;
          frame_pos++;
        end else begin
          // The last byte carries the checksum; a corrupt frame reports all zeros.
          if (b == frame_sum) begin
            capped           = (strength_raw > STRENGTH_CAP) ? STRENGTH_CAP : strength_raw;
            res.range_mm     = 20'(dist_cm) * 20'd10;
            res.strength_pct = capped[6:0];
            res.status       = (capped < 16'(weak_cfg)) ? STATUS_WEAK : STATUS_GOOD;
          end else begin
            res.status = STATUS_BAD;
          end
          expected_results.push_back(res);
          parser_phase = PH_HUNT1;
          frame_pos    = 0;
          frame_sum    = '0;
        end
      end
      default: begin
        if (b == hdr_cfg) begin
          frame_sum    = b;
          frame_pos    = 1;
          dist_cm      = '0;
          strength_raw = '0;
          parser_phase = PH_HUNT2;
        end else begin
          parser_phase = PH_HUNT1;
          frame_pos    = 0;
          frame_sum    = '0;
        end
      end
    endcase
  endtask

  // Compares one received result with the oldest expectation.
  task automatic check_result(input logic [31:0] data);
    range_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: tdata 0x%08h", data);
      mismatch_cnt++;
    end else begin
      want = expected_results.pop_front();
      if (data[19:0] !== want.range_mm) begin
        $error("range_mm: expected %0d, got %0d", want.range_mm, data[19:0]);
        mismatch_cnt++;
      end
      if (data[26:20] !== want.strength_pct) begin
        $error("strength_pct: expected %0d, got %0d", want.strength_pct, data[26:20]);
        mismatch_cnt++;
      end
      if (data[28:27] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[28:27]);
        mismatch_cnt++;
      end
    end
  endtask

  // Byte driver: feeds the stream from the pending queue, with random gaps between transfers while idle_in is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) track_frame_byte(s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap        <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= byte_queue.pop_front();
          send_gap        <= idle_in ? pick_gap() : 0;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and stalls the output at random while idle_out is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
      if (stall_left != 0) begin
        stall_left      <= stall_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (idle_out && $urandom_range(0, 3) == 0) begin
        stall_left      <= pick_gap();
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transfer has happened for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Queues one frame; the checksum is deliberately wrong when bad_sum is set.
  task automatic queue_frame(input logic [15:0] dist_word, input logic [15:0] str,
                             input logic [7:0] spare0, input logic [7:0] spare1,
                             input bit bad_sum);
    logic [7:0] body[8];
    logic [7:0] sum;
    body = '{hdr_cfg, hdr_cfg, dist_word[7:0], dist_word[15:8], str[7:0], str[15:8],
             spare0, spare1};
    sum  = '0;
    foreach (body[k]) begin
      byte_queue.push_back(body[k]);
      sum = sum + body[k];
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    byte_queue.push_back(sum);
  endtask

  // Random traffic: mostly well-formed frames, some broken headers, cut frames and noise.
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    logic [15:0] dist_word;
    logic [15:0] str;
    logic [7:0]  sp0;
    logic [7:0]  sp1;
    start = byte_queue.size();
    while (byte_queue.size() - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        n = $urandom_range(0, 9);
        dist_word = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom);
        n = $urandom_range(0, 9);
        if (n < 5) str = 16'($urandom_range(0, 130));
        else if (n < 7) str = 16'(weak_cfg) + 16'($urandom_range(0, 1)) - 16'd1;
        else str = 16'($urandom);
        sp0 = ($urandom_range(0, 3) == 0) ? hdr_cfg : 8'($urandom);
        sp1 = ($urandom_range(0, 3) == 0) ? hdr_cfg : 8'($urandom);
        queue_frame(dist_word, str, sp0, sp1, $urandom_range(0, 99) < 15);
      end else if (r < 82) begin
        // First header followed by a byte that is not a header.
        byte_queue.push_back(hdr_cfg);
        byte_queue.push_back(hdr_cfg + 8'($urandom_range(1, 255)));
      end else if (r < 90) begin
        // A header pair with a short body; the following bytes complete it.
        byte_queue.push_back(hdr_cfg);
        byte_queue.push_back(hdr_cfg);
        n = $urandom_range(0, 6);
        repeat (n) byte_queue.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) byte_queue.push_back(($urandom_range(0, 3) == 0) ? hdr_cfg : 8'($urandom));
      end
    end
  endtask

  // Waits until every byte is sent and every result has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the header register, then the weak-limit register, and updates the shadow copies.
  task automatic write_config(input logic [7:0] hdr, input logic [7:0] weak_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_HEADER;
    cfg_data_i <= hdr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WEAK;
    cfg_data_i <= weak_lim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
    hdr_cfg  = hdr;
    weak_cfg = weak_lim[6:0];
  endtask

  // Stimulus: directed frames at reset settings, then random phases over several settings.
  initial begin
    logic [7:0] hdr;
    logic [7:0] weak_lim;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Broken header pair, a full-scale frame with header bytes in its body,
    // a weak frame and a frame with a corrupt checksum.
    byte_queue.push_back(hdr_cfg);
    byte_queue.push_back(8'h00);
    queue_frame(16'hFFFF, 16'hFFFF, hdr_cfg, hdr_cfg, 1'b0);
    queue_frame(16'h0000, 16'(WEAK_RESET) - 16'd1, 8'hFF, 8'h00, 1'b0);
    queue_frame(16'h1234, 16'h0050, 8'hAA, 8'h55, 1'b1);
    queue_random_traffic(200);

    for (int i = 0; i < 5; i++) begin
      wait_drained();
      case (i)
        0: begin hdr = 8'h00; weak_lim = 8'd0;   end
        1: begin hdr = 8'hFF; weak_lim = 8'd100; end
        2: begin hdr = 8'hA5; weak_lim = 8'hFF;  end
        default: begin
          hdr      = 8'($urandom);
          weak_lim = 8'($urandom_range(0, 127));
        end
      endcase
      write_config(hdr, weak_lim);
      idle_in  = (i != 2);
      idle_out = (i != 2 && i != 3);
      queue_random_traffic(235);
    end

    do @(negedge clk_i);
    while (byte_queue.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
